[hdl/srer_pkg.sv]
// srer_pkg: shared types and codes for the sparse row edge removal filter.
// Used by every module of the block; no dependencies.

package srer_pkg;

    // Request codes on req_type
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_ADD   = 2'd1,
        OP_EDGE  = 2'd2,
        OP_END   = 2'd3
    } op_t;

    // Result codes on out_kind
    typedef enum logic [1:0] {
        KIND_EDGE   = 2'd0,
        KIND_ROWPTR = 2'd1,
        KIND_FULL   = 2'd2
    } kind_t;

    localparam int OP_W       = 2;
    localparam int COL_W      = 32;
    localparam int POS_W      = 32;
    localparam int GROUP_SIZE = 8;   // match bits folded per first-level OR

endpackage

[hdl/srer_front.sv]
// srer_front: accepts request words, holds the ids_given register and the
// running edge position, and forms the lookup key for each word.
// Depends on srer_pkg.

module srer_front #(
    parameter int ID_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  req_type,
    input  logic [31:0]                 in_id,
    input  logic [srer_pkg::COL_W-1:0]  column_in,
    input  logic                        cfg_we,
    input  logic                        cfg_data,
    input  logic                        q_full,
    output logic                        q_push,
    output srer_pkg::op_t               q_op,
    output logic [ID_WIDTH-1:0]         q_key,
    output logic [srer_pkg::COL_W-1:0]  q_column
);

    logic                       ids_given_reg, ids_given_next;
    logic [srer_pkg::POS_W-1:0] edge_pos_reg, edge_pos_next;
    logic                       accept;
    srer_pkg::op_t              op;

    assign op       = srer_pkg::op_t'(req_type);
    assign in_stall = q_full;
    assign accept   = in_valid & ~q_full;
    assign q_push   = accept;
    assign q_op     = op;
    assign q_column = column_in;

    always_comb
    begin
        case (op)
            srer_pkg::OP_EDGE:
            begin
                q_key = ids_given_reg ? ID_WIDTH'(in_id) : ID_WIDTH'(edge_pos_reg);
            end
            default:
            begin
                q_key = ID_WIDTH'(in_id);
            end
        endcase
    end

    always_comb
    begin
        ids_given_next = cfg_we ? cfg_data : ids_given_reg;
        edge_pos_next  = edge_pos_reg;
        if (accept && op == srer_pkg::OP_START)
        begin
            edge_pos_next = '0;
        end
        else if (accept && op == srer_pkg::OP_EDGE)
        begin
            edge_pos_next = edge_pos_reg + 1'b1;   // wraps at 2^32
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ids_given_reg <= 1'b0;
            edge_pos_reg  <= '0;
        end
        else
        begin
            ids_given_reg <= ids_given_next;
            edge_pos_reg  <= edge_pos_next;
        end
    end

endmodule

[hdl/srer_queue.sv]
// srer_queue: two-entry FIFO of classified requests between front and back.
// Depends on srer_pkg.

module srer_queue #(
    parameter int ID_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  srer_pkg::op_t               push_op,
    input  logic [ID_WIDTH-1:0]         push_key,
    input  logic [srer_pkg::COL_W-1:0]  push_column,
    output logic                        full,
    input  logic                        pop,
    output logic                        not_empty,
    output srer_pkg::op_t               pop_op,
    output logic [ID_WIDTH-1:0]         pop_key,
    output logic [srer_pkg::COL_W-1:0]  pop_column
);

    localparam int W = srer_pkg::OP_W + ID_WIDTH + srer_pkg::COL_W;

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic [W-1:0] rd_word;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign rd_word   = mem_reg[rd_ptr_reg];

    assign pop_op     = srer_pkg::op_t'(rd_word[W-1 -: srer_pkg::OP_W]);
    assign pop_key    = rd_word[srer_pkg::COL_W +: ID_WIDTH];
    assign pop_column = rd_word[srer_pkg::COL_W-1:0];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= {push_op, push_key, push_column};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[hdl/srer_back.sv]
// srer_back: removal set (CAM with fill count), compare stage, decide stage
// and the output register.
// Depends on srer_pkg.

module srer_back #(
    parameter int SET_DEPTH = 64,
    parameter int ID_WIDTH  = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_not_empty,
    output logic                        q_pop,
    input  srer_pkg::op_t               q_op,
    input  logic [ID_WIDTH-1:0]         q_key,
    input  logic [srer_pkg::COL_W-1:0]  q_column,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  out_kind,
    output logic [31:0]                 out_column,
    output logic [31:0]                 out_edge_id,
    output logic [31:0]                 out_row_pointer
);

    localparam int G    = srer_pkg::GROUP_SIZE;
    localparam int NGRP = (SET_DEPTH + G - 1) / G;
    localparam int CW   = $clog2(SET_DEPTH + 1);
    localparam int AW   = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;

    // removal set storage, valid below the fill count
    logic [ID_WIDTH-1:0] ids_reg [SET_DEPTH];
    logic [CW-1:0]       count_reg, count_next;
    logic [31:0]         kept_reg, kept_next;

    // compare stage
    logic                       s1_valid_reg, s1_valid_next;
    srer_pkg::op_t              s1_op_reg;
    logic [ID_WIDTH-1:0]        s1_key_reg;
    logic [srer_pkg::COL_W-1:0] s1_col_reg;
    logic [NGRP-1:0]            s1_grp_reg, grp_next;
    logic [NGRP*G-1:0]          hit_vec;

    // output register
    logic                 out_valid_reg, out_valid_next;
    srer_pkg::kind_t      out_kind_reg;
    logic [31:0]          out_col_reg, out_eid_reg, out_rp_reg;

    // decide
    logic            out_free, fire, hit, set_full;
    logic            has_res, ins, clr, keep;
    srer_pkg::kind_t res_kind;
    logic [31:0]     res_col, res_eid, res_rp;
    logic            fwd, zap;

    assign out_free = ~out_valid_reg | ~out_stall;
    assign fire     = s1_valid_reg & out_free;
    assign q_pop    = q_not_empty & (~s1_valid_reg | fire);

    always_comb
    begin
        hit      = |s1_grp_reg;
        set_full = (count_reg == CW'(SET_DEPTH));
        has_res  = 1'b0;
        ins      = 1'b0;
        clr      = 1'b0;
        keep     = 1'b0;
        res_kind = srer_pkg::KIND_EDGE;
        res_col  = '0;
        res_eid  = '0;
        res_rp   = '0;
        case (s1_op_reg)
            srer_pkg::OP_START:
            begin
                clr      = 1'b1;
                has_res  = 1'b1;
                res_kind = srer_pkg::KIND_ROWPTR;
            end
            srer_pkg::OP_ADD:
            begin
                if (!hit)
                begin
                    if (set_full)
                    begin
                        has_res  = 1'b1;
                        res_kind = srer_pkg::KIND_FULL;
                    end
                    else
                    begin
                        ins = 1'b1;
                    end
                end
            end
            srer_pkg::OP_EDGE:
            begin
                if (!hit)
                begin
                    keep     = 1'b1;
                    has_res  = 1'b1;
                    res_kind = srer_pkg::KIND_EDGE;
                    res_col  = s1_col_reg;
                    res_eid  = 32'(s1_key_reg);
                end
            end
            srer_pkg::OP_END:
            begin
                has_res  = 1'b1;
                res_kind = srer_pkg::KIND_ROWPTR;
                res_rp   = kept_reg;
            end
            default:
            begin
                has_res = 1'b0;
            end
        endcase
    end

    // compare the word leaving the queue against the set; the word in the
    // decide stage lands in the set (or clears it) at this same edge
    always_comb
    begin
        hit_vec = '0;
        for (int e = 0; e < SET_DEPTH; e++)
        begin
            hit_vec[e] = (CW'(e) < count_reg) && (ids_reg[e] == q_key);
        end
        fwd = fire & ins & (q_key == s1_key_reg);
        zap = fire & clr;
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = ~zap & (|hit_vec[g*G +: G]);
        end
        grp_next[0] = grp_next[0] | fwd;
    end

    always_comb
    begin
        count_next = count_reg;
        kept_next  = kept_reg;
        if (fire && clr)
        begin
            count_next = '0;
            kept_next  = '0;
        end
        else
        begin
            if (fire && ins)
            begin
                count_next = count_reg + 1'b1;
            end
            if (fire && keep)
            begin
                kept_next = kept_reg + 1'b1;
            end
        end

        if (q_pop)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (fire && has_res)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && ins)
        begin
            ids_reg[count_reg[AW-1:0]] <= s1_key_reg;
        end
        if (q_pop)
        begin
            s1_op_reg  <= q_op;
            s1_key_reg <= q_key;
            s1_col_reg <= q_column;
            s1_grp_reg <= grp_next;
        end
        if (fire && has_res)
        begin
            out_kind_reg <= res_kind;
            out_col_reg  <= res_col;
            out_eid_reg  <= res_eid;
            out_rp_reg   <= res_rp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            kept_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            kept_reg      <= kept_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_kind        = out_kind_reg;
    assign out_column      = out_col_reg;
    assign out_edge_id     = out_eid_reg;
    assign out_row_pointer = out_rp_reg;

endmodule

[hdl/sparse_row_edge_removal_filter_core.sv]
// sparse_row_edge_removal_filter_core: top level of the CSR edge removal
// filter. Depends on srer_pkg, srer_front, srer_queue, srer_back.
//
//   channel   direction  handshake           payload
//   ------------------------------------------------------------------------
//   request   in         in_valid/in_stall   req_type, in_id, column_in
//   result    out        out_valid/out_stall out_kind, out_column,
//                                            out_edge_id, out_row_pointer
//   config    in         cfg_we              cfg_data (ids_given)
//
// One word per cycle sustained while out_stall is low. A word passes three
// registers (queue, compare stage, output register) before out_valid rises.
// The compare stage checks the key against every set entry at once and
// folds the match bits in groups of eight; the decide stage ORs the groups.
// Reset clears the counters and the fill count, which stands in for per-entry
// valid flags; no clearing pass. in_stall rises only when the two-entry queue
// is full; out_stall holds the output register and backs up through decide
// and compare.
//
// A word whose compare overlaps an insert or a start in the decide stage
// picks that effect up by forwarding, so back-to-back adds and edges with
// the same ID see each other.

module sparse_row_edge_removal_filter_core #(
    parameter int SET_DEPTH = 64,
    parameter int ID_WIDTH  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // request
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [31:0] in_id,
    input  logic [31:0] column_in,
    // result
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  out_kind,
    output logic [31:0] out_column,
    output logic [31:0] out_edge_id,
    output logic [31:0] out_row_pointer,
    // ids_given register
    input  logic        cfg_we,
    input  logic        cfg_data
);

    logic                       q_full, q_push, q_pop, q_not_empty;
    srer_pkg::op_t              f_op, b_op;
    logic [ID_WIDTH-1:0]        f_key, b_key;
    logic [srer_pkg::COL_W-1:0] f_col, b_col;

    srer_front #(
        .ID_WIDTH (ID_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .in_id     (in_id),
        .column_in (column_in),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_op      (f_op),
        .q_key     (f_key),
        .q_column  (f_col)
    );

    srer_queue #(
        .ID_WIDTH (ID_WIDTH)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (q_push),
        .push_op     (f_op),
        .push_key    (f_key),
        .push_column (f_col),
        .full        (q_full),
        .pop         (q_pop),
        .not_empty   (q_not_empty),
        .pop_op      (b_op),
        .pop_key     (b_key),
        .pop_column  (b_col)
    );

    srer_back #(
        .SET_DEPTH (SET_DEPTH),
        .ID_WIDTH  (ID_WIDTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_not_empty     (q_not_empty),
        .q_pop           (q_pop),
        .q_op            (b_op),
        .q_key           (b_key),
        .q_column        (b_col),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_kind        (out_kind),
        .out_column      (out_column),
        .out_edge_id     (out_edge_id),
        .out_row_pointer (out_row_pointer)
    );

endmodule

[hdl/srer_checker.sv]
// srer_checker: port-level checks on the filter's result channel, bound to
// the top level. Depends on srer_pkg.

module srer_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  out_kind,
    input logic [31:0] out_column,
    input logic [31:0] out_edge_id,
    input logic [31:0] out_row_pointer
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_kind)
            && $stable(out_column) && $stable(out_edge_id) && $stable(out_row_pointer))
        else $error("result word changed under stall");

    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_kind == srer_pkg::KIND_EDGE || out_kind == srer_pkg::KIND_ROWPTR
            || out_kind == srer_pkg::KIND_FULL))
        else $error("unknown result kind");

    a_rowptr_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == srer_pkg::KIND_ROWPTR |-> out_column == 32'd0
            && out_edge_id == 32'd0)
        else $error("row pointer carries edge fields");

    a_edge_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == srer_pkg::KIND_EDGE |-> out_row_pointer == 32'd0)
        else $error("kept edge carries a row pointer");

    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == srer_pkg::KIND_FULL |-> out_column == 32'd0
            && out_edge_id == 32'd0 && out_row_pointer == 32'd0)
        else $error("set full error carries data");

endmodule

bind sparse_row_edge_removal_filter_core srer_checker u_srer_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_column      (out_column),
    .out_edge_id     (out_edge_id),
    .out_row_pointer (out_row_pointer)
);
